@@ hw/rtl/cfr_pkg.sv @@
// Shared types and constants for the command frame responder.
package cfr_pkg;

	localparam logic [15:0] HdrWord      = 16'hA700;
	localparam logic [7:0]  HdrByte      = 8'hA7;
	localparam logic [15:0] VersionReset = 16'h0102;
	localparam logic [8:0]  VoltMax      = 9'd300;

	localparam logic [15:0] HdrIdent    = 16'hA700;
	localparam logic [15:0] HdrStatus   = 16'hA710;
	localparam logic [15:0] HdrSetParam = 16'hA780;
	localparam logic [15:0] HdrSetFire  = 16'hA790;
	localparam logic [15:0] HdrSave     = 16'hA7F0;

	localparam logic [3:0] CMD_IDENT     = 4'h0;
	localparam logic [3:0] CMD_STATUS    = 4'h1;
	localparam logic [3:0] CMD_SET_PARAM = 4'h8;
	localparam logic [3:0] CMD_SET_FIRE  = 4'h9;
	localparam logic [3:0] CMD_SAVE      = 4'hF;

	localparam logic [15:0] SUB_DEVICE  = 16'd1;
	localparam logic [15:0] SUB_BAUD    = 16'd2;
	localparam logic [15:0] SUB_VOLTAGE = 16'd0;
	localparam logic [15:0] SUB_TYPE    = 16'd1;

	typedef logic [3:0] op_t;

	localparam op_t OP_REJECT   = 4'd0;
	localparam op_t OP_IDENT    = 4'd1;
	localparam op_t OP_STATUS   = 4'd2;
	localparam op_t OP_SET_DEV  = 4'd3;
	localparam op_t OP_SET_BAUD = 4'd4;
	localparam op_t OP_SET_NONE = 4'd5;
	localparam op_t OP_SET_VOLT = 4'd6;
	localparam op_t OP_SET_TYPE = 4'd7;
	localparam op_t OP_SAVE     = 4'd8;

	typedef struct packed {
		op_t         op;
		logic [15:0] value;
	} entry_t;

endpackage

@@ hw/rtl/cfr_in_if.sv @@
// Handshake channel for received command frames.
interface cfr_in_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [3:0]  frame_length;
	logic [15:0] word_zero;
	logic [15:0] word_one;
	logic [15:0] word_two;

	modport source (output valid, frame_ok, frame_length, word_zero, word_one, word_two,
		input ready);
	modport sink (input valid, frame_ok, frame_length, word_zero, word_one, word_two,
		output ready);
endinterface

@@ hw/rtl/cfr_out_if.sv @@
// Handshake channel for response words.
interface cfr_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [15:0] resp_word;
	logic        last_word;
	logic [15:0] reply_baud;
	logic        save_pulse;
	logic [8:0]  voltage_out;

	modport source (output valid, accepted, resp_word, last_word, reply_baud, save_pulse,
		voltage_out, input ready);
	modport sink (input valid, accepted, resp_word, last_word, reply_baud, save_pulse,
		voltage_out, output ready);
endinterface

@@ hw/rtl/command_frame_responder.sv @@
// Top level of the command frame responder.
// A frame's first response item is registered first in the operation queue and then in the output register.
// One frame per cycle for one-word replies while the reply is not stalled; identify and status
// emit three response items each, as the executor emits one response item per cycle when not stalled.
// A two-entry operation queue lets frames be taken while response items are stalled.
// Reset clears all settings to zero, version_word to 0x0102, and empties queue and output.
module command_frame_responder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	cfr_in_if.sink      frame,
	cfr_out_if.source   reply,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cfr_pkg::*;

	localparam logic REG_VERSION = 1'b0;

	logic [15:0] version_q;
	logic        cfg_wr;
	logic        q_ready;
	logic        push;
	entry_t      push_entry;
	logic        pop;
	logic        head_valid;
	entry_t      head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VERSION);
	assign prdata = (paddr[2] == REG_VERSION) ? {16'd0, version_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VersionReset;
		end else if (cfg_wr) begin
			version_q <= pwdata[15:0];
		end
	end

	cfr_front u_front (
		.frame   (frame),
		.q_ready (q_ready),
		.push    (push),
		.entry   (push_entry)
	);

	cfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.ready      (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	cfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.version_word (version_q),
		.pop          (pop),
		.reply        (reply)
	);

endmodule

@@ hw/rtl/cfr_front.sv @@
// Frame checker: validates a frame and classifies it into an operation.
module cfr_front (
	cfr_in_if.sink          frame,
	input  logic            q_ready,
	output logic            push,
	output cfr_pkg::entry_t entry
);
	import cfr_pkg::*;

	logic       hdr_ok;
	logic       short_ok;
	logic       long_ok;
	logic [3:0] cmd;
	op_t        op;

	assign hdr_ok   = frame.frame_ok && (frame.frame_length != 4'd0) &&
		(frame.word_zero[15:8] == HdrByte);
	assign short_ok = (frame.frame_length == 4'd1) || (frame.frame_length == 4'd2);
	assign long_ok  = (frame.frame_length == 4'd3) || (frame.frame_length == 4'd4);
	assign cmd      = frame.word_zero[7:4];

	always_comb begin
		op = OP_REJECT;
		if (hdr_ok) begin
			case (cmd)
				CMD_IDENT: begin
					if (short_ok) op = OP_IDENT;
				end
				CMD_STATUS: begin
					if (short_ok) op = OP_STATUS;
				end
				CMD_SET_PARAM: begin
					if (long_ok) begin
						if (frame.word_one == SUB_DEVICE) op = OP_SET_DEV;
						else if (frame.word_one == SUB_BAUD) op = OP_SET_BAUD;
						else op = OP_SET_NONE;
					end
				end
				CMD_SET_FIRE: begin
					if (long_ok) begin
						if (frame.word_one == SUB_VOLTAGE) op = OP_SET_VOLT;
						else if (frame.word_one == SUB_TYPE) op = OP_SET_TYPE;
					end
				end
				CMD_SAVE: begin
					if (short_ok) op = OP_SAVE;
				end
				default: op = OP_REJECT;
			endcase
		end
	end

	always_comb begin
		entry.op = op;
		case (op)
			OP_SET_BAUD: entry.value = frame.word_two - 16'd1;
			OP_SET_VOLT: entry.value = (frame.word_two > {7'd0, VoltMax}) ?
				{7'd0, VoltMax} : frame.word_two;
			OP_SET_TYPE: entry.value = {15'd0, |frame.word_two};
			default:     entry.value = frame.word_two;
		endcase
	end

	assign frame.ready = q_ready;
	assign push        = frame.valid && q_ready;

endmodule

@@ hw/rtl/cfr_queue.sv @@
// Short queue of classified operations between checker and executor.
module cfr_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfr_pkg::entry_t push_entry,
	output logic            ready,
	input  logic            pop,
	output logic            head_valid,
	output cfr_pkg::entry_t head
);
	import cfr_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign ready      = (count_q != CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/cfr_back.sv @@
// Executor: holds the settings, applies updates and emits response words.
module cfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  cfr_pkg::entry_t head,
	input  logic [15:0]     version_word,
	output logic            pop,
	cfr_out_if.source       reply
);
	import cfr_pkg::*;

	logic [15:0] device_q;
	logic [8:0]  volt_q;
	logic        type_q;
	logic [15:0] baud_q;
	logic [1:0]  idx_q;

	logic        out_valid_q;
	logic        accepted_q;
	logic [15:0] resp_q;
	logic        last_q;
	logic [15:0] baud_out_q;
	logic        save_q;
	logic [8:0]  volt_out_q;

	logic        adv;
	logic        multi;
	logic        last;
	logic [15:0] word;
	logic [15:0] baud_nx;
	logic [8:0]  volt_nx;

	assign adv   = head_valid && (!out_valid_q || reply.ready);
	assign multi = (head.op == OP_IDENT) || (head.op == OP_STATUS);
	assign last  = !multi || (idx_q == 2'd2);
	assign pop   = adv && last;

	assign baud_nx = (head.op == OP_SET_BAUD) ? head.value : baud_q;
	assign volt_nx = (head.op == OP_SET_VOLT) ? head.value[8:0] : volt_q;

	always_comb begin
		case (head.op)
			OP_IDENT: begin
				case (idx_q)
					2'd0:    word = HdrIdent;
					2'd1:    word = device_q;
					default: word = version_word;
				endcase
			end
			OP_STATUS: begin
				case (idx_q)
					2'd0:    word = HdrStatus;
					2'd1:    word = {7'd0, volt_q};
					default: word = {15'd0, type_q};
				endcase
			end
			OP_SET_DEV, OP_SET_BAUD, OP_SET_NONE: word = HdrSetParam;
			OP_SET_VOLT, OP_SET_TYPE:             word = HdrSetFire;
			OP_SAVE:                              word = HdrSave;
			default:                              word = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_q    <= '0;
			volt_q      <= '0;
			type_q      <= 1'b0;
			baud_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
				case (head.op)
					OP_SET_DEV:  device_q <= head.value;
					OP_SET_BAUD: baud_q   <= head.value;
					OP_SET_VOLT: volt_q   <= head.value[8:0];
					OP_SET_TYPE: type_q   <= head.value[0];
					default: ;
				endcase
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted_q <= (head.op != OP_REJECT);
			resp_q     <= word;
			last_q     <= last;
			baud_out_q <= baud_nx;
			save_q     <= (head.op == OP_SAVE);
			volt_out_q <= volt_nx;
		end
	end

	assign reply.valid       = out_valid_q;
	assign reply.accepted    = accepted_q;
	assign reply.resp_word   = resp_q;
	assign reply.last_word   = last_q;
	assign reply.reply_baud  = baud_out_q;
	assign reply.save_pulse  = save_q;
	assign reply.voltage_out = volt_out_q;

	a_volt_range: assert property (@(posedge clk) disable iff (!arst_n)
		volt_q <= VoltMax)
		else $error("voltage setting above limit");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd3) && ((idx_q == 2'd0) || multi))
		else $error("word index out of range for operation");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !accepted_q |-> last_q && (resp_q == 16'd0) && !save_q)
		else $error("malformed reject item");

	a_idx_held: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(idx_q))
		else $error("word index moved without an item");

endmodule

@@ tb/sv/command_frame_responder_checker.sv @@
// Checker for the command frame responder: predicts reply items per frame and compares them.
module command_frame_responder_checker #(
	parameter logic [2:0] VersionAddr = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	cfr_in_if           frame,
	cfr_out_if          reply,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          outstanding
);
	import cfr_pkg::*;

	typedef struct packed {
		logic        accepted;
		logic [15:0] word;
		logic        last;
		logic [15:0] baud;
		logic        save;
		logic [8:0]  volt;
	} reply_item_t;

	reply_item_t expected_replies[$];

	logic [15:0] version_word    = VersionReset;
	logic [15:0] device_number   = '0;
	logic [8:0]  voltage_setting = '0;
	logic        type_setting    = 1'b0;
	logic [15:0] baud_setting    = '0;
	int          errors          = 0;

	assign fail_count = errors;

	task automatic push_reply(input logic acc, input logic [15:0] word, input logic last,
		input logic save);
		reply_item_t item;
		item.accepted = acc;
		item.word     = word;
		item.last     = last;
		item.baud     = baud_setting;
		item.save     = save;
		item.volt     = voltage_setting;
		expected_replies.push_back(item);
	endtask

	task automatic answer_frame(input logic ok, input logic [3:0] len, input logic [15:0] w0,
		input logic [15:0] w1, input logic [15:0] w2);
		logic short_len;
		logic long_len;
		logic rejected;
		short_len = (len >= 4'd1) && (len <= 4'd2);
		long_len  = (len >= 4'd3) && (len <= 4'd4);
		rejected  = 1'b0;
		if (!ok || len == 4'd0 || w0[15:8] != HdrByte) begin
			rejected = 1'b1;
		end else begin
			case (w0[7:4])
				CMD_IDENT: begin
					if (short_len) begin
						push_reply(1'b1, HdrIdent, 1'b0, 1'b0);
						push_reply(1'b1, device_number, 1'b0, 1'b0);
						push_reply(1'b1, version_word, 1'b1, 1'b0);
					end else begin
						rejected = 1'b1;
					end
				end
				CMD_STATUS: begin
					if (short_len) begin
						push_reply(1'b1, HdrStatus, 1'b0, 1'b0);
						push_reply(1'b1, {7'd0, voltage_setting}, 1'b0, 1'b0);
						push_reply(1'b1, {15'd0, type_setting}, 1'b1, 1'b0);
					end else begin
						rejected = 1'b1;
					end
				end
				CMD_SET_PARAM: begin
					if (long_len) begin
						if (w1 == SUB_DEVICE) begin
							device_number = w2;
						end else if (w1 == SUB_BAUD) begin
							baud_setting = w2 - 16'd1;
						end
						push_reply(1'b1, HdrSetParam, 1'b1, 1'b0);
					end else begin
						rejected = 1'b1;
					end
				end
				CMD_SET_FIRE: begin
					if (long_len && w1 == SUB_VOLTAGE) begin
						voltage_setting = (w2 > {7'd0, VoltMax}) ? VoltMax : w2[8:0];
						push_reply(1'b1, HdrSetFire, 1'b1, 1'b0);
					end else if (long_len && w1 == SUB_TYPE) begin
						type_setting = (w2 != 16'd0);
						push_reply(1'b1, HdrSetFire, 1'b1, 1'b0);
					end else begin
						rejected = 1'b1;
					end
				end
				CMD_SAVE: begin
					if (short_len) begin
						push_reply(1'b1, HdrSave, 1'b1, 1'b1);
					end else begin
						rejected = 1'b1;
					end
				end
				default: rejected = 1'b1;
			endcase
		end
		if (rejected) begin
			push_reply(1'b0, 16'd0, 1'b1, 1'b0);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic compare_reply();
		reply_item_t want;
		if (expected_replies.size() == 0) begin
			$error("reply item with no frame waiting: resp_word %0h", reply.resp_word);
			errors++;
		end else begin
			want = expected_replies.pop_front();
			check_field("accepted", {15'd0, want.accepted}, {15'd0, reply.accepted});
			check_field("resp_word", want.word, reply.resp_word);
			check_field("last_word", {15'd0, want.last}, {15'd0, reply.last_word});
			check_field("reply_baud", want.baud, reply.reply_baud);
			check_field("save_pulse", {15'd0, want.save}, {15'd0, reply.save_pulse});
			check_field("voltage_out", {7'd0, want.volt}, {7'd0, reply.voltage_out});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_word    = VersionReset;
			device_number   = '0;
			voltage_setting = '0;
			type_setting    = 1'b0;
			baud_setting    = '0;
			expected_replies.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == VersionAddr) begin
				version_word = pwdata[15:0];
			end
			if (frame.valid && frame.ready) begin
				answer_frame(frame.frame_ok, frame.frame_length, frame.word_zero,
					frame.word_one, frame.word_two);
			end
			if (reply.valid && reply.ready) begin
				compare_reply();
			end
			outstanding <= expected_replies.size();
		end
	end

endmodule

@@ tb/sv/command_frame_responder_test.sv @@
// Testbench top for the command frame responder: clock, reset, frame stimulus and verdict.
module command_frame_responder_test;
	import cfr_pkg::*;

	localparam logic [2:0] VersionAddr = 3'd0;
	localparam int WatchdogLimit = 1000;
	localparam int LongHold = 60;

	typedef struct packed {
		logic        ok;
		logic [3:0]  len;
		logic [15:0] w0;
		logic [15:0] w1;
		logic [15:0] w2;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          outstanding;
	int          tx_idle_pct = 27;
	int          rx_idle_pct = 60;
	int          stall_requests = 0;
	int          stall_seen = 0;
	int          idle_cycles = 0;

	cfr_in_if  frame_ch ();
	cfr_out_if reply_ch ();

	command_frame_responder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.reply   (reply_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	command_frame_responder_checker #(
		.VersionAddr (VersionAddr)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame_ch),
		.reply       (reply_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (reply_ch.valid && reply_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : receiver
		int hold;
		reply_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_seen != stall_requests) begin
				stall_seen = stall_requests;
				reply_ch.ready <= 1'b0;
				for (hold = 0; hold < LongHold; hold++) @(posedge clk);
			end else begin
				reply_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic frame_t make_frame(input logic ok, input logic [3:0] len,
		input logic [15:0] w0, input logic [15:0] w1, input logic [15:0] w2);
		frame_t f;
		f.ok  = ok;
		f.len = len;
		f.w0  = w0;
		f.w1  = w1;
		f.w2  = w2;
		return f;
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'd1;
			2: return {7'd0, VoltMax};
			3: return {7'd0, VoltMax} + 16'd1;
			4: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		logic [3:0] cmd;
		f.ok  = 1'b1;
		f.w1  = 16'($urandom_range(65535));
		f.w2  = pick_value();
		case ($urandom_range(4))
			0: cmd = CMD_IDENT;
			1: cmd = CMD_STATUS;
			2: cmd = CMD_SET_PARAM;
			3: cmd = CMD_SET_FIRE;
			default: cmd = CMD_SAVE;
		endcase
		if (cmd == CMD_SET_PARAM || cmd == CMD_SET_FIRE) begin
			f.len = 4'($urandom_range(4, 3));
		end else begin
			f.len = 4'($urandom_range(2, 1));
		end
		if (cmd == CMD_SET_PARAM && $urandom_range(9) < 8) begin
			f.w1 = $urandom_range(1) ? SUB_DEVICE : SUB_BAUD;
		end else if (cmd == CMD_SET_FIRE && $urandom_range(9) < 8) begin
			f.w1 = $urandom_range(1) ? SUB_VOLTAGE : SUB_TYPE;
		end
		f.w0 = {HdrByte, cmd, 4'($urandom_range(15))};
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(4))
				0: begin
					f.ok  = 1'($urandom_range(1));
					f.len = 4'($urandom_range(10));
					f.w0  = $urandom_range(1) ? {HdrByte, 8'($urandom_range(255))}
						: 16'($urandom_range(65535));
				end
				1: f.ok = 1'b0;
				2: f.len = 4'($urandom_range(10));
				3: f.w0[15:8] = HdrByte ^ 8'($urandom_range(255, 1));
				default: f.w0[7:4] = 4'($urandom_range(15));
			endcase
		end
		return f;
	endfunction

	task automatic send_frame(input frame_t f);
		if ($urandom_range(99) < tx_idle_pct) begin
			frame_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.frame_ok     <= f.ok;
		frame_ch.frame_length <= f.len;
		frame_ch.word_zero    <= f.w0;
		frame_ch.word_one     <= f.w1;
		frame_ch.word_two     <= f.w2;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
	endtask

	task automatic drain_replies();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_version(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= VersionAddr;
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic run_random(input int count, input int stall_at);
		for (int n = 0; n < count; n++) begin
			if (n == stall_at) stall_requests <= stall_requests + 1;
			send_frame(random_frame());
		end
	endtask

	task automatic run_directed();
		logic [15:0] ident;
		logic [15:0] status;
		logic [15:0] set_param;
		logic [15:0] set_fire;
		logic [15:0] save;
		ident     = {HdrByte, CMD_IDENT, 4'h0};
		status    = {HdrByte, CMD_STATUS, 4'hF};
		set_param = {HdrByte, CMD_SET_PARAM, 4'h0};
		set_fire  = {HdrByte, CMD_SET_FIRE, 4'h5};
		save      = {HdrByte, CMD_SAVE, 4'h0};
		send_frame(make_frame(1'b1, 4'd1, ident, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd2, status, 16'hFFFF, 16'hFFFF));
		send_frame(make_frame(1'b1, 4'd3, set_param, SUB_DEVICE, 16'hFFFF));
		send_frame(make_frame(1'b1, 4'd4, set_param, SUB_BAUD, 16'h0000));
		send_frame(make_frame(1'b1, 4'd3, set_param, 16'h0007, 16'h1234));
		send_frame(make_frame(1'b1, 4'd4, set_fire, SUB_VOLTAGE, 16'd301));
		send_frame(make_frame(1'b1, 4'd1, status, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd3, set_fire, SUB_VOLTAGE, 16'hFFFF));
		send_frame(make_frame(1'b1, 4'd3, set_fire, SUB_VOLTAGE, 16'd300));
		send_frame(make_frame(1'b1, 4'd3, set_fire, SUB_TYPE, 16'd5));
		send_frame(make_frame(1'b1, 4'd2, ident, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd3, set_fire, 16'h0002, 16'h0010));
		send_frame(make_frame(1'b1, 4'd1, save, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b0, 4'd1, ident, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd0, save, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd1, 16'hA600, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd1, {HdrByte, 4'h2, 4'h0}, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd3, ident, 16'h0000, 16'h0000));
		send_frame(make_frame(1'b1, 4'd2, set_param, SUB_DEVICE, 16'h0001));
		send_frame(make_frame(1'b1, 4'd10, save, 16'hFFFF, 16'hFFFF));
		send_frame(make_frame(1'b1, 4'd4, set_param, SUB_BAUD, 16'hFFFF));
		send_frame(make_frame(1'b1, 4'd4, set_fire, SUB_VOLTAGE, 16'd0));
		send_frame(make_frame(1'b1, 4'd4, set_fire, SUB_TYPE, 16'd0));
		send_frame(make_frame(1'b1, 4'd2, status, 16'h0000, 16'h0000));
	endtask

	initial begin
		arst_n                <= 1'b0;
		frame_ch.valid        <= 1'b0;
		frame_ch.frame_ok     <= 1'b0;
		frame_ch.frame_length <= '0;
		frame_ch.word_zero    <= '0;
		frame_ch.word_one     <= '0;
		frame_ch.word_two     <= '0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain_replies();
		write_version(16'hFFFF);
		run_random(150, 50);

		drain_replies();
		tx_idle_pct = 60;
		rx_idle_pct = 27;
		write_version(16'h0000);
		run_random(150, 80);

		drain_replies();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_version(16'($urandom_range(65535)));
		run_random(150, -1);

		drain_replies();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
